FILE: rtl/ltd_pkg.sv
// package for the lru tag directory: constants and shared types
`timescale 1ns / 1ps
package ltd_pkg;
  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned AreaCountDef  = 2;
  localparam int unsigned StampWidthDef = 32;
  localparam int unsigned TagWidth      = 32;
  localparam int unsigned BufWidth      = 5;
  localparam int unsigned CfgWidth      = 6;
  localparam logic [TagWidth-1:0] FreeTag = 32'hFFFF_FFFF;

  localparam logic [1:0] ModeFind  = 2'd0;
  localparam logic [1:0] ModeAlloc = 2'd1;
  localparam logic [1:0] ModeVict  = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic CfgClusterEntries = 1'b0;
  localparam logic CfgDataEntries    = 1'b1;

  // command from the sequencer to every cell of one area, per cycle
  typedef struct packed {
    logic shift;   // rotate the ring by one cell
    logic sort;    // bubble compare-swap pass step
    logic clr_tag; // free the tag held at the head cell
    logic wr_tag;  // write new tag at the head cell
    logic wr_stamp;
    logic renum;   // write renumber stamp at the head cell
  } ltd_cmd_t;
endpackage

FILE: rtl/ltd_cell.sv
// one directory entry: tag, stamp and buffer number
`timescale 1ns / 1ps
module ltd_cell #(
  parameter int unsigned StampWidth = ltd_pkg::StampWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ltd_pkg::BufWidth-1:0]    rst_buf_i,
  input  logic                            load_i,
  input  logic [ltd_pkg::TagWidth-1:0]    tag_i,
  input  logic [StampWidth-1:0]           stamp_i,
  input  logic [ltd_pkg::BufWidth-1:0]    buf_i,
  output logic [ltd_pkg::TagWidth-1:0]    tag_o,
  output logic [StampWidth-1:0]           stamp_o,
  output logic [ltd_pkg::BufWidth-1:0]    buf_o
);
  import ltd_pkg::*;
  logic [TagWidth-1:0]   tag_q;
  logic [StampWidth-1:0] stamp_q;
  logic [BufWidth-1:0]   buf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= FreeTag;
      stamp_q <= '0;
      buf_q   <= rst_buf_i;
    end else if (load_i) begin
      tag_q   <= tag_i;
      stamp_q <= stamp_i;
      buf_q   <= buf_i;
    end
  end
  assign tag_o   = tag_q;
  assign stamp_o = stamp_q;
  assign buf_o   = buf_q;
endmodule

FILE: rtl/lru_tag_directory.sv
// lru tag directory top level: cell rings per area and the request sequencer
// sequence: find/allocate scan one turn of the ring, victim a scan turn plus an
//   install turn, clear one turn; with no entries in use the response follows idle
//   directly; renumbering before find/allocate adds sort passes and a renumber turn
// throughput: one item at a time, set by the single ring rotation per area
// reset: every tag free, stamps and clocks zero, buffer number = slot index
`timescale 1ns / 1ps
module lru_tag_directory #(
  parameter int unsigned MaxEntries = ltd_pkg::MaxEntriesDef,
  parameter int unsigned AreaCount  = ltd_pkg::AreaCountDef,
  parameter int unsigned StampWidth = ltd_pkg::StampWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [ltd_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode[1:0], area[2], tag[34:3], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status, buffer_number, old_tag_valid, old_tag
);
  import ltd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxEntries + 1);
  localparam int unsigned AW   = (AreaCount > 1) ? $clog2(AreaCount) : 1;
  localparam logic [StampWidth-1:0] RenumAt = {{(StampWidth-1){1'b1}}, 1'b0};

  typedef enum logic [2:0] {
    StIdle, StScan, StSortPass, StRenum, StFinish, StOut
  } state_e;

  // ring per area: cell k loads from cell k+1 on shift; last loads from head
  // (possibly modified). sort step swaps the head pair through the ring.
  logic [TagWidth-1:0]   tag_w   [AreaCount][MaxEntries];
  logic [StampWidth-1:0] stamp_w [AreaCount][MaxEntries];
  logic [BufWidth-1:0]   buf_w   [AreaCount][MaxEntries];
  logic [TagWidth-1:0]   tag_n   [AreaCount][MaxEntries];
  logic [StampWidth-1:0] stamp_n [AreaCount][MaxEntries];
  logic [BufWidth-1:0]   buf_n   [AreaCount][MaxEntries];
  logic                  ld      [AreaCount][MaxEntries];

  logic [CfgWidth-1:0] cfg0_q, cfg1_q;
  logic [StampWidth-1:0] clk_q [AreaCount];

  state_e state_q;
  logic [1:0]          mode_q;
  logic [AW-1:0]       area_q;
  logic [TagWidth-1:0] tag_q;
  logic [IdxW-1:0]     n_q, pos_q, pass_q;
  logic                found_q;
  logic [IdxW-1:0]     pick_q;
  logic [StampWidth-1:0] best_q;
  logic                o_status_q, o_otv_q;
  logic [BufWidth-1:0] o_buf_q;
  logic [TagWidth-1:0] o_old_q;
  logic                area_ok;
  logic [IdxW-1:0]     n_sel;
  logic [1:0]          in_mode;
  logic [AW-1:0]       in_area;
  logic                in_area_hi;
  ltd_cmd_t            cmd;

  // head is cell 0 of the selected area; writes happen as the head moves to the tail
  logic [TagWidth-1:0]   h_tag, h2_tag;
  logic [StampWidth-1:0] h_stamp, h2_stamp;
  logic [BufWidth-1:0]   h_buf, h2_buf;
  logic                  sw;

  assign in_mode = s_axis_tdata[1:0];
  assign in_area_hi = (AreaCount < 2) ? s_axis_tdata[2] : 1'b0;
  assign in_area = (AreaCount < 2) ? '0 : AW'(s_axis_tdata[2]);
  assign area_ok = (AreaCount >= 2) || !in_area_hi;

  always_comb begin
    logic [CfgWidth-1:0] c;
    c = CfgWidth'(MaxEntries > 63 ? 63 : MaxEntries);
    if (in_area == AW'(0)) c = cfg0_q;
    else if (in_area == AW'(1)) c = cfg1_q;
    if (in_area > AW'(1) || 32'(c) > MaxEntries) n_sel = IdxW'(MaxEntries);
    else n_sel = IdxW'(c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg0_q <= CfgWidth'(16);
      cfg1_q <= CfgWidth'(32);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgClusterEntries) cfg0_q <= cfg_data_i;
      else cfg1_q <= cfg_data_i;
    end
  end

  // head pair and swap decision for the sort pass
  assign h_tag    = tag_w[area_q][0];
  assign h_stamp  = stamp_w[area_q][0];
  assign h_buf    = buf_w[area_q][0];
  assign h2_tag   = tag_w[area_q][(MaxEntries > 1) ? 1 : 0];
  assign h2_stamp = stamp_w[area_q][(MaxEntries > 1) ? 1 : 0];
  assign h2_buf   = buf_w[area_q][(MaxEntries > 1) ? 1 : 0];
  // carried element sits at head; compares with next; larger is carried on
  assign sw = (h_stamp > h2_stamp);

  // cell datapath: only the first n_q cells of the selected area rotate
  always_comb begin
    for (int a = 0; a < AreaCount; a++) begin
      for (int k = 0; k < MaxEntries; k++) begin
        ld[a][k] = 1'b0;
        tag_n[a][k] = tag_w[a][k];
        stamp_n[a][k] = stamp_w[a][k];
        buf_n[a][k] = buf_w[a][k];
        if (cmd.shift && a == int'(area_q) && k < int'(n_q)) begin
          ld[a][k] = 1'b1;
          if (k == int'(n_q) - 1) begin
            if (cmd.sort && sw && pos_q < n_q - IdxW'(1)) begin
              // sort emits the smaller of the head pair to the tail
              tag_n[a][k] = h2_tag;
              stamp_n[a][k] = h2_stamp;
              buf_n[a][k] = h2_buf;
            end else begin
              tag_n[a][k] = cmd.clr_tag ? FreeTag : (cmd.wr_tag ? tag_q : h_tag);
              stamp_n[a][k] = cmd.renum ? StampWidth'(pos_q)
                            : (cmd.wr_stamp ? clk_q[a] : h_stamp);
              buf_n[a][k] = h_buf;
            end
          end else if (k == 0 && cmd.sort && sw && pos_q < n_q - IdxW'(1)) begin
            // keep carried element at head, emit the smaller one
            tag_n[a][k] = h_tag;
            stamp_n[a][k] = h_stamp;
            buf_n[a][k] = h_buf;
          end else begin
            tag_n[a][k] = tag_w[a][(k + 1 < MaxEntries) ? k + 1 : k];
            stamp_n[a][k] = stamp_w[a][(k + 1 < MaxEntries) ? k + 1 : k];
            buf_n[a][k] = buf_w[a][(k + 1 < MaxEntries) ? k + 1 : k];
          end
        end
      end
    end
  end

  for (genvar a = 0; a < AreaCount; a++) begin : g_area
    for (genvar k = 0; k < MaxEntries; k++) begin : g_cell
      ltd_cell #(.StampWidth(StampWidth)) u_cell (
        .clk_i, .rst_ni,
        .rst_buf_i(BufWidth'(k)),
        .load_i(ld[a][k]),
        .tag_i(tag_n[a][k]), .stamp_i(stamp_n[a][k]), .buf_i(buf_n[a][k]),
        .tag_o(tag_w[a][k]), .stamp_o(stamp_w[a][k]), .buf_o(buf_w[a][k])
      );
    end
  end

  // per-cycle command to the ring
  always_comb begin
    logic hit_now;
    cmd = '0;
    hit_now = 1'b0;
    if (state_q == StScan) begin
      cmd.shift = 1'b1;
      if (mode_q == ModeFind)
        hit_now = !found_q && h_tag != FreeTag && h_tag == tag_q;
      else
        hit_now = !found_q && h_tag == FreeTag;
      if (mode_q == ModeClear) cmd.clr_tag = 1'b1;
      else if (mode_q != ModeVict && hit_now) begin
        cmd.wr_stamp = 1'b1;
        cmd.wr_tag = (mode_q == ModeAlloc);
      end
    end else if (state_q == StSortPass) begin
      cmd.shift = 1'b1;
      cmd.sort = 1'b1;
    end else if (state_q == StRenum) begin
      cmd.shift = 1'b1;
      cmd.renum = 1'b1;
    end else if (state_q == StFinish) begin
      // second turn for victim: install at pick
      cmd.shift = 1'b1;
      if (pos_q == pick_q) begin
        cmd.wr_tag = 1'b1;
        cmd.wr_stamp = 1'b1;
      end
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {1'b0, o_old_q, o_otv_q, o_buf_q, o_status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int a = 0; a < AreaCount; a++) clk_q[a] <= '0;
      mode_q <= ModeFind; area_q <= '0; tag_q <= '0; n_q <= '0; pos_q <= '0;
      pass_q <= '0; found_q <= 1'b0; pick_q <= '0; best_q <= '0;
      o_status_q <= 1'b1; o_otv_q <= 1'b0; o_buf_q <= '0; o_old_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            mode_q <= in_mode; area_q <= in_area; tag_q <= s_axis_tdata[34:3];
            n_q <= n_sel; pos_q <= '0; pass_q <= '0; found_q <= 1'b0;
            pick_q <= '0; best_q <= '1;
            o_status_q <= !(area_ok && in_mode == ModeClear);
            o_otv_q <= 1'b0; o_buf_q <= '0; o_old_q <= '0;
            if (!area_ok) state_q <= StOut;
            else if (in_mode == ModeClear) begin
              clk_q[in_area] <= '0;
              state_q <= (n_sel == '0) ? StOut : StScan;
            end else if (n_sel == '0) begin
              // renumbering an empty area only resets its clock
              if (in_mode != ModeVict && clk_q[in_area] >= RenumAt) clk_q[in_area] <= '0;
              state_q <= StOut;
            end else if (in_mode != ModeVict && clk_q[in_area] >= RenumAt)
              state_q <= StSortPass;
            else state_q <= StScan;
          end
        end
        StSortPass: begin
          if (pos_q == n_q - IdxW'(1)) begin
            pos_q <= '0;
            pass_q <= pass_q + IdxW'(1);
            if (pass_q + IdxW'(1) >= n_q) state_q <= StRenum;
          end else pos_q <= pos_q + IdxW'(1);
        end
        StRenum: begin
          if (pos_q == n_q - IdxW'(1)) begin
            pos_q <= '0;
            clk_q[area_q] <= StampWidth'(n_q);
            state_q <= StScan;
          end else pos_q <= pos_q + IdxW'(1);
        end
        StScan: begin
          if (mode_q == ModeFind || mode_q == ModeAlloc) begin
            if (cmd.wr_stamp) begin
              found_q <= 1'b1;
              o_status_q <= 1'b0;
              o_buf_q <= h_buf;
              clk_q[area_q] <= clk_q[area_q] + StampWidth'(1);
            end
          end else if (mode_q == ModeVict && !found_q) begin
            if (h_tag == FreeTag) begin
              found_q <= 1'b1; pick_q <= pos_q; o_buf_q <= h_buf;
              o_old_q <= h_tag; o_otv_q <= 1'b0;
            end else if (pos_q == '0 || h_stamp < best_q) begin
              pick_q <= pos_q; best_q <= h_stamp; o_buf_q <= h_buf;
              o_old_q <= h_tag; o_otv_q <= 1'b1;
            end
          end
          if (pos_q == n_q - IdxW'(1)) begin
            pos_q <= '0;
            if (mode_q == ModeVict) begin
              o_status_q <= 1'b0;
              state_q <= StFinish;
            end else state_q <= StOut;
          end else pos_q <= pos_q + IdxW'(1);
        end
        StFinish: begin
          if (pos_q == pick_q) clk_q[area_q] <= clk_q[area_q] + StampWidth'(1);
          if (pos_q == n_q - IdxW'(1)) begin
            pos_q <= '0;
            state_q <= StOut;
          end else pos_q <= pos_q + IdxW'(1);
        end
        StOut: begin
          if (m_axis_tready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  logic unused_bits;
  assign unused_bits = ^{s_axis_tdata[39:35]};
endmodule

FILE: test/tb_lru_tag_directory.sv
// testbench for the lru tag directory: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module tb_lru_tag_directory;
  import ltd_pkg::*;

  // one expected response of the directory
  typedef struct {
    logic        status;
    logic [4:0]  buf_num;
    logic        old_valid;
    logic [31:0] old_tag;
  } dir_resp_t;

  // predictor of the directory plus the queue of responses still owed
  class dir_scoreboard;
    logic [31:0] tags[2][32];
    logic [31:0] stamps[2][32];
    logic [4:0]  bufs[2][32];
    logic [31:0] clocks[2];
    logic [5:0]  entries[2];
    dir_resp_t   owed[$];
    int          mismatches;
    int          checked;
    int          hits;
    int          victims_full;

    function new();
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 32; i++) begin
          tags[a][i]   = FreeTag;
          stamps[a][i] = '0;
          bufs[a][i]   = i[4:0];
        end
        clocks[a] = '0;
      end
      entries[0] = 6'd16;
      entries[1] = 6'd32;
    endfunction

    function void set_entries(logic idx, logic [5:0] val);
      entries[idx] = val;
    endfunction

    function int unsigned in_use(int a);
      return (entries[a] > 32) ? 32 : entries[a];
    endfunction

    // stable sort by stamp and renumber once the clock is about to wrap
    function void renumber(int a, int unsigned n);
      logic [31:0] t, s;
      logic [4:0]  b;
      int          j;
      if (clocks[a] < 32'hFFFF_FFFE) return;
      for (int i = 1; i < n; i++) begin
        t = tags[a][i]; s = stamps[a][i]; b = bufs[a][i];
        j = i;
        while (j > 0 && stamps[a][j-1] > s) begin
          tags[a][j] = tags[a][j-1]; stamps[a][j] = stamps[a][j-1];
          bufs[a][j] = bufs[a][j-1];
          j--;
        end
        tags[a][j] = t; stamps[a][j] = s; bufs[a][j] = b;
      end
      for (int i = 0; i < n; i++) stamps[a][i] = i;
      clocks[a] = n;
    endfunction

    function void touch(int a, int i);
      stamps[a][i] = clocks[a];
      clocks[a]    = clocks[a] + 1;
    endfunction

    // accepted request: work out its response and queue it
    function void note_request(logic [1:0] mode, logic area, logic [31:0] tag);
      dir_resp_t   r;
      int          a;
      int unsigned n;
      int          pick;
      bit          found;
      a = area;
      n = in_use(a);
      r = '{1'b1, 5'd0, 1'b0, 32'd0};
      pick = 0;
      found = 0;
      if (mode == ModeClear) begin
        for (int i = 0; i < n; i++) tags[a][i] = FreeTag;
        clocks[a] = '0;
        r.status = 1'b0;
      end else if (mode == ModeFind || mode == ModeAlloc) begin
        renumber(a, n);
        for (int i = 0; i < n && !found; i++) begin
          if (mode == ModeFind ? (tags[a][i] != FreeTag && tags[a][i] == tag)
                               : (tags[a][i] == FreeTag)) begin
            found = 1; pick = i;
          end
        end
        if (found) begin
          if (mode == ModeAlloc) tags[a][pick] = tag;
          else hits++;
          touch(a, pick);
          r.status  = 1'b0;
          r.buf_num = bufs[a][pick];
        end
      end else if (n != 0) begin
        for (int i = 0; i < n; i++) begin
          if (tags[a][i] == FreeTag) begin
            pick = i; found = 1; break;
          end
          if (stamps[a][i] < stamps[a][pick]) pick = i;
        end
        if (!found) victims_full++;
        r.status    = 1'b0;
        r.buf_num   = bufs[a][pick];
        r.old_valid = tags[a][pick] != FreeTag;
        r.old_tag   = tags[a][pick];
        tags[a][pick] = tag;
        touch(a, pick);
      end
      owed.push_back(r);
    endfunction

    // accepted response: compare with the oldest owed one
    function void check_response(logic [39:0] d);
      dir_resp_t e;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", d);
        return;
      end
      e = owed.pop_front();
      if (d[0] !== e.status || d[5:1] !== e.buf_num || d[6] !== e.old_valid ||
          d[38:7] !== e.old_tag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp status %0d buf %0d old_valid %0d old_tag %h, got %0d %0d %0d %h",
                   e.status, e.buf_num, e.old_valid, e.old_tag, d[0], d[5:1], d[6], d[38:7]);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [5:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // mode[1:0], area[2], tag[34:3], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // status[0], buffer_number[5:1], old_tag_valid[6], old_tag[38:7]

  dir_scoreboard sb;
  int          tx_idle_pct;   // sender idles this many cycles in a hundred
  int          rx_idle_pct;   // receiver idles this many cycles in a hundred
  bit          hold_req;      // asks the receiver for a long stall
  int          quiet_cycles;
  logic [31:0] tag_pool[24];

  lru_tag_directory u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver side: random stalls, or one long stall when asked
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = $urandom_range(99) >= rx_idle_pct;
      end
    end
  end

  // monitor both handshakes at the rising edge, plus the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata[1:0], s_axis_tdata[2], s_axis_tdata[34:3]);
      if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("watchdog: no progress");
        $display("Verification failed");
        $finish;
      end
    end
  end

  // offer one request and return at the edge where it is taken
  task automatic send_request(logic [1:0] mode, logic area, logic [31:0] tag);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'd0, tag, area, mode};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // register writes happen only with nothing in flight
  task automatic write_entries(logic idx, logic [5:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    sb.set_entries(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // mostly pool tags so finds hit, some full range, a few free markers
  function automatic logic [31:0] pick_tag();
    int r;
    r = $urandom_range(99);
    if (r < 3) return FreeTag;
    if (r < 15) return $urandom;
    return tag_pool[$urandom_range(23)];
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ModeFind;
    if (r < 68) return ModeAlloc;
    if (r < 95) return ModeVict;
    return ModeClear;
  endfunction

  initial begin
    logic [5:0] cfg_sets[6][2];
    int         sent;
    sb = new();
    cfg_sets = '{'{6'd16, 6'd32}, '{6'd1, 6'd3}, '{6'd32, 6'd0},
                 '{6'd63, 6'd33}, '{6'd5, 6'd17}, '{6'd2, 6'd8}};
    for (int i = 0; i < 24; i++) tag_pool[i] = (i < 12) ? i : ~i;
    tx_idle_pct   = 26;
    rx_idle_pct   = 54;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset sizes, extreme tags, the free marker, every mode
    send_request(ModeFind,  1'b0, 32'd0);          // miss on empty area
    send_request(ModeAlloc, 1'b0, 32'd0);
    send_request(ModeAlloc, 1'b0, 32'hFFFF_FFFE);
    send_request(ModeFind,  1'b0, 32'hFFFF_FFFE);  // hit
    send_request(ModeFind,  1'b0, FreeTag);        // free marker never hits
    send_request(ModeAlloc, 1'b1, FreeTag);        // stamped but stays free
    send_request(ModeVict,  1'b1, 32'h5555_AAAA);  // free entry chosen
    send_request(ModeClear, 1'b0, 32'd0);
    send_request(ModeFind,  1'b0, 32'd0);          // gone after clear
    // one entry in area zero: full allocate, victim replaces, oldest wins
    write_entries(CfgClusterEntries, 6'd1);
    send_request(ModeAlloc, 1'b0, 32'd7);
    send_request(ModeAlloc, 1'b0, 32'd8);          // no free entry
    send_request(ModeVict,  1'b0, 32'd9);          // old tag 7 returned
    send_request(ModeFind,  1'b0, 32'd9);
    // zero entries: everything misses, clear still succeeds
    write_entries(CfgClusterEntries, 6'd0);
    send_request(ModeFind,  1'b0, 32'd9);
    send_request(ModeAlloc, 1'b0, 32'd9);
    send_request(ModeVict,  1'b0, 32'd9);
    send_request(ModeClear, 1'b0, 32'd9);
    // above the maximum: saturated to a full area
    write_entries(CfgDataEntries, 6'd63);
    send_request(ModeVict,  1'b1, 32'd1);
    send_request(ModeFind,  1'b1, 32'd1);
    send_request(ModeClear, 1'b1, 32'd0);
    // two entries, both full: victim takes the oldest stamp
    write_entries(CfgClusterEntries, 6'd2);
    send_request(ModeAlloc, 1'b0, 32'd20);
    send_request(ModeAlloc, 1'b0, 32'd21);
    send_request(ModeFind,  1'b0, 32'd20);
    send_request(ModeVict,  1'b0, 32'd22);         // 20 holds the oldest stamp; 21 found no free entry
    send_request(ModeVict,  1'b0, 32'd23);

    // random part over several sizes; idling pattern moves on by item count
    sent = 0;
    for (int p = 0; p < 6; p++) begin
      write_entries(CfgClusterEntries, cfg_sets[p][0]);
      write_entries(CfgDataEntries, cfg_sets[p][1]);
      for (int k = 0; k < 240; k++) begin
        if (sent == 480) begin
          tx_idle_pct = 54;
          rx_idle_pct = 26;
        end else if (sent == 960) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // long receiver stall while the sender keeps offering
          hold_req = 1'b1;
        end else if (sent == 1200) begin
          // sender pause until every response is in
          wait_idle();
        end
        send_request(pick_mode(), $urandom_range(1), pick_tag());
        sent++;
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("covered %0d responses: %0d find hits, %0d victims of full areas, six sizings",
             sb.checked, sb.hits, sb.victims_full);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/ltd_pkg.sv
rtl/ltd_cell.sv
rtl/lru_tag_directory.sv
test/tb_lru_tag_directory.sv
